@@ hw/rtl/cma_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cma_pkg
// Shared types, constants and calendar helpers for the calendar minute adder.
// ----------------------------------------------------------------------------
package cma_pkg;

  // width of the minute amount that counts
  localparam int ADD_WIDTH = 20;
  // working width: minute register plus amount, one carry bit
  localparam int MIN_W     = ADD_WIDTH + 1;
  localparam int CNT_W     = $clog2(MIN_W);
  localparam int REM_W     = 7;

  localparam int DAY_W     = 5;
  localparam int MONTH_W   = 4;
  localparam int YEAR_W    = 14;
  localparam int HOUR_W    = 5;
  localparam int MINUTE_W  = 6;

  // command codes on in_func
  localparam logic FUNC_LOAD = 1'b0;
  localparam logic FUNC_ADD  = 1'b1;

  localparam logic [MINUTE_W-1:0] MINS_PER_HOUR   = 6'd60;
  localparam logic [HOUR_W-1:0]   HOURS_PER_DAY   = 5'd24;
  localparam logic [MONTH_W-1:0]  MONTHS_PER_YEAR = 4'd12;
  localparam logic [YEAR_W-1:0]   MAX_YEAR        = 14'd9999;
  localparam logic [DAY_W-1:0]    MAX_DAY         = 5'd31;

  // divisibility by 25 via the modular inverse of 25 modulo 2**14
  localparam logic [YEAR_W-1:0]   INV25_MOD       = 14'd7209;
  localparam logic [YEAR_W-1:0]   DIV25_LIMIT     = 14'd655;

  localparam logic [MONTH_W-1:0]  MON_FEB = 4'd2;
  localparam logic [MONTH_W-1:0]  MON_APR = 4'd4;
  localparam logic [MONTH_W-1:0]  MON_JUN = 4'd6;
  localparam logic [MONTH_W-1:0]  MON_SEP = 4'd9;
  localparam logic [MONTH_W-1:0]  MON_NOV = 4'd11;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV60,
    ST_DIV24,
    ST_WALK
  } cma_state_t;

  typedef logic [MIN_W-1:0] cma_word_t;

  // result of the shared compare and subtract unit
  typedef struct packed {
    logic      ge;
    logic      gt;
    cma_word_t diff;
  } cma_cmp_t;

  function automatic logic is_leap(input logic [YEAR_W-1:0] y);
    logic [YEAR_W-1:0] prod;
    logic              d25;
    logic              m4;
    logic              m16;
    prod = y * INV25_MOD;
    d25  = (prod <= DIV25_LIMIT);
    m4   = (y[1:0] == 2'd0);
    m16  = (y[3:0] == 4'd0);
    return (m4 && !d25) || (m16 && d25);
  endfunction

  function automatic logic [DAY_W-1:0] days_in(input logic [MONTH_W-1:0] m,
                                               input logic               leap);
    logic [DAY_W-1:0] d;
    unique case (m)
      MON_FEB:                           d = leap ? 5'd29 : 5'd28;
      MON_APR, MON_JUN, MON_SEP, MON_NOV: d = 5'd30;
      default:                           d = 5'd31;
    endcase
    return d;
  endfunction

endpackage

@@ hw/rtl/cma_subcmp.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cma_subcmp
// Shared compare and subtract unit: a - b with greater-or-equal and greater.
// ----------------------------------------------------------------------------
module cma_subcmp (
  input  cma_pkg::cma_word_t a,
  input  cma_pkg::cma_word_t b,
  output cma_pkg::cma_cmp_t  res
);
  import cma_pkg::*;

  logic [MIN_W:0] wide;

  assign wide     = {1'b0, a} - {1'b0, b};
  assign res.diff = wide[MIN_W-1:0];
  assign res.ge   = ~wide[MIN_W];
  assign res.gt   = ~wide[MIN_W] && (wide[MIN_W-1:0] != '0);

endmodule

@@ hw/rtl/calendar_minute_adder.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// calendar_minute_adder
// Gregorian date and time register that loads a date or adds minutes to it.
// ----------------------------------------------------------------------------
//
//  channel   | handshake            | payload
//  ----------+----------------------+-----------------------------------------
//  input     | start / busy         | in_func, in_load_*, in_add_amount
//  result    | out_valid (strobe)   | out_cur_*, out_year_overflow
//
//  a load's result strobe follows in the next cycle
//  an add runs the divide by 60, then the divide by 24 (one quotient bit
//    a cycle), then the month by month walk, all on the single shared
//    compare and subtract unit
//  busy is high from an add transfer until its result strobe; a load never raises busy
//  reset brings the date to 01-01-0001 00:00, no result pending
//  the receiver cannot stall: each result stands for one cycle only
//
module calendar_minute_adder (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  logic                          in_func,
  input  logic [cma_pkg::DAY_W-1:0]     in_load_day,
  input  logic [cma_pkg::MONTH_W-1:0]   in_load_month,
  input  logic [cma_pkg::YEAR_W-1:0]    in_load_year,
  input  logic [cma_pkg::HOUR_W-1:0]    in_load_hour,
  input  logic [cma_pkg::MINUTE_W-1:0]  in_load_minute,
  input  logic [19:0]                   in_add_amount,
  output logic                          out_valid,
  output logic [cma_pkg::DAY_W-1:0]     out_cur_day,
  output logic [cma_pkg::MONTH_W-1:0]   out_cur_month,
  output logic [cma_pkg::YEAR_W-1:0]    out_cur_year,
  output logic [cma_pkg::HOUR_W-1:0]    out_cur_hour,
  output logic [cma_pkg::MINUTE_W-1:0]  out_cur_minute,
  output logic                          out_year_overflow
);
  import cma_pkg::*;

  // control state
  cma_state_t          state_r, state_nxt;
  logic                valid_r, valid_nxt;
  logic                ovf_r, ovf_nxt;
  // calendar registers, also the result registers
  logic [DAY_W-1:0]    day_r, day_nxt;
  logic [MONTH_W-1:0]  month_r, month_nxt;
  logic [YEAR_W-1:0]   year_r, year_nxt;
  logic [HOUR_W-1:0]   hour_r, hour_nxt;
  logic [MINUTE_W-1:0] minute_r, minute_nxt;
  // datapath: dividend / quotient shifter, then the running day count
  cma_word_t           dvd_r, dvd_nxt;
  logic [REM_W-1:0]    rem_r, rem_nxt;
  logic [CNT_W-1:0]    cnt_r, cnt_nxt;
  logic                leap_r, leap_nxt;

  // shared unit operands
  cma_word_t           op_a, op_b;
  cma_cmp_t            cmp;
  logic [REM_W-1:0]    step_val;
  cma_word_t           quot;
  logic [DAY_W-1:0]    mon_days;
  logic                accept;

  assign accept   = start && (state_r == ST_IDLE);
  assign busy     = (state_r != ST_IDLE);

  // leap flag is a register fed from the year, so it trails it; a year step is always followed
  // by january, so february never sees a stale flag
  assign leap_nxt = is_leap(year_r);
  assign mon_days = days_in(month_r, leap_r);

  // one restoring division step: shift next dividend bit into the remainder
  assign step_val = {rem_r[REM_W-2:0], dvd_r[MIN_W-1]};
  assign quot     = {dvd_r[MIN_W-2:0], cmp.ge};

  always_comb begin
    if (state_r == ST_WALK) begin
      op_a = dvd_r;
      op_b = MIN_W'(mon_days);
    end else begin
      op_a = MIN_W'(step_val);
      op_b = (state_r == ST_DIV60) ? MIN_W'(MINS_PER_HOUR) : MIN_W'(HOURS_PER_DAY);
    end
  end

  cma_subcmp u_subcmp (
    .a   (op_a),
    .b   (op_b),
    .res (cmp)
  );

  // sequencer: next state and datapath updates
  always_comb begin
    state_nxt  = state_r;
    valid_nxt  = 1'b0;
    ovf_nxt    = ovf_r;
    day_nxt    = day_r;
    month_nxt  = month_r;
    year_nxt   = year_r;
    hour_nxt   = hour_r;
    minute_nxt = minute_r;
    dvd_nxt    = dvd_r;
    rem_nxt    = rem_r;
    cnt_nxt    = cnt_r;

    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          ovf_nxt = 1'b0;
          if (in_func == FUNC_LOAD) begin
            // load with each field clamped into its range
            day_nxt    = (in_load_day == '0) ? DAY_W'(1) : in_load_day;
            month_nxt  = (in_load_month == '0) ? MONTH_W'(1) :
                         (in_load_month > MONTHS_PER_YEAR) ? MONTHS_PER_YEAR :
                         in_load_month;
            year_nxt   = (in_load_year == '0) ? YEAR_W'(1) :
                         (in_load_year > MAX_YEAR) ? MAX_YEAR : in_load_year;
            hour_nxt   = (in_load_hour >= HOURS_PER_DAY) ?
                         HOUR_W'(HOURS_PER_DAY - 5'd1) : in_load_hour;
            minute_nxt = (in_load_minute >= MINS_PER_HOUR) ?
                         MINUTE_W'(MINS_PER_HOUR - 6'd1) : in_load_minute;
            valid_nxt  = 1'b1;
          end else begin
            dvd_nxt   = MIN_W'(in_add_amount[ADD_WIDTH-1:0]) + MIN_W'(minute_r);
            rem_nxt   = '0;
            cnt_nxt   = CNT_W'(MIN_W - 1);
            state_nxt = ST_DIV60;
          end
        end
      end

      ST_DIV60, ST_DIV24: begin
        rem_nxt = cmp.ge ? cmp.diff[REM_W-1:0] : step_val;
        dvd_nxt = quot;
        cnt_nxt = cnt_r - CNT_W'(1);
        if (cnt_r == '0) begin
          rem_nxt = '0;
          cnt_nxt = CNT_W'(MIN_W - 1);
          if (state_r == ST_DIV60) begin
            minute_nxt = cmp.ge ? cmp.diff[MINUTE_W-1:0] : step_val[MINUTE_W-1:0];
            dvd_nxt    = quot + MIN_W'(hour_r);
            state_nxt  = ST_DIV24;
          end else begin
            hour_nxt  = cmp.ge ? cmp.diff[HOUR_W-1:0] : step_val[HOUR_W-1:0];
            dvd_nxt   = quot + MIN_W'(day_r);
            state_nxt = ST_WALK;
          end
        end
      end

      ST_WALK: begin
        if (cmp.gt) begin
          // day count still beyond this month: step to the next one
          dvd_nxt = cmp.diff;
          if (month_r == MONTHS_PER_YEAR) begin
            month_nxt = MONTH_W'(1);
            if (year_r >= MAX_YEAR) begin
              // saturate at the last minute of the last year
              day_nxt    = MAX_DAY;
              month_nxt  = MONTHS_PER_YEAR;
              year_nxt   = MAX_YEAR;
              hour_nxt   = HOUR_W'(HOURS_PER_DAY - 5'd1);
              minute_nxt = MINUTE_W'(MINS_PER_HOUR - 6'd1);
              ovf_nxt    = 1'b1;
              valid_nxt  = 1'b1;
              state_nxt  = ST_IDLE;
            end else begin
              year_nxt = year_r + YEAR_W'(1);
            end
          end else begin
            month_nxt = month_r + MONTH_W'(1);
          end
        end else begin
          day_nxt   = dvd_r[DAY_W-1:0];
          valid_nxt = 1'b1;
          state_nxt = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // control and calendar registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      valid_r  <= 1'b0;
      ovf_r    <= 1'b0;
      day_r    <= DAY_W'(1);
      month_r  <= MONTH_W'(1);
      year_r   <= YEAR_W'(1);
      hour_r   <= '0;
      minute_r <= '0;
    end else begin
      state_r  <= state_nxt;
      valid_r  <= valid_nxt;
      ovf_r    <= ovf_nxt;
      day_r    <= day_nxt;
      month_r  <= month_nxt;
      year_r   <= year_nxt;
      hour_r   <= hour_nxt;
      minute_r <= minute_nxt;
    end
  end

  // datapath registers, no reset needed
  always_ff @(posedge clk) begin
    dvd_r  <= dvd_nxt;
    rem_r  <= rem_nxt;
    cnt_r  <= cnt_nxt;
    leap_r <= leap_nxt;
  end

  // result ports come straight from the calendar registers
  assign out_valid         = valid_r;
  assign out_cur_day       = day_r;
  assign out_cur_month     = month_r;
  assign out_cur_year      = year_r;
  assign out_cur_hour      = hour_r;
  assign out_cur_minute    = minute_r;
  assign out_year_overflow = ovf_r;

  // a result strobe only ever appears with the sequencer back at rest
  a_strobe_idle: assert property (@(posedge clk) disable iff (!rst_n)
    valid_r |-> (state_r == ST_IDLE))
    else $error("result strobe while sequencer busy");

  // a load transfer gives its result in the very next cycle
  a_load_one_cycle: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && in_func == FUNC_LOAD) |=> valid_r)
    else $error("load result missing");

  // overflow reports carry the saturated date
  a_ovf_saturated: assert property (@(posedge clk) disable iff (!rst_n)
    (valid_r && ovf_r) |-> (day_r == MAX_DAY && month_r == MONTHS_PER_YEAR &&
                            year_r == MAX_YEAR))
    else $error("overflow without saturated date");

  // the month walk always keeps a legal month
  a_walk_month: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_WALK) |-> (month_r != '0 && month_r <= MONTHS_PER_YEAR))
    else $error("month out of range during walk");

  // an add transfer always goes through the divide by 60 first
  a_add_div: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && in_func == FUNC_ADD) |=> (state_r == ST_DIV60 && !valid_r))
    else $error("add did not enter division");

endmodule

@@ test/tb_calendar_minute_adder.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_calendar_minute_adder
// Self-checking bench for the calendar minute adder. A queue of commands
// (loads and minute additions) is played through the start / busy port in
// bursts with random gaps. Each transfer is run through a local calendar
// predictor and the expected date is queued. Every result strobe is checked
// field by field against the oldest expected date.
// ----------------------------------------------------------------------------
module tb_calendar_minute_adder;
  import cma_pkg::*;

  localparam int          RANDOM_ITEMS = 1450;
  localparam int          CYCLE_LIMIT  = 1_000_000;
  localparam int          DRAIN_CYCLES = 120;

  localparam int unsigned HOUR_MINS  = 32'(MINS_PER_HOUR);
  localparam int unsigned DAY_HOURS  = 32'(HOURS_PER_DAY);
  localparam int unsigned YEAR_MONS  = 32'(MONTHS_PER_YEAR);
  localparam int unsigned LAST_YEAR  = 32'(MAX_YEAR);
  localparam int unsigned LAST_DAY   = 32'(MAX_DAY);

  typedef struct packed {
    logic                func;
    logic [DAY_W-1:0]    day;
    logic [MONTH_W-1:0]  month;
    logic [YEAR_W-1:0]   year;
    logic [HOUR_W-1:0]   hour;
    logic [MINUTE_W-1:0] minute;
    logic [19:0]         amount;
  } cal_cmd_t;

  typedef struct packed {
    logic [DAY_W-1:0]    day;
    logic [MONTH_W-1:0]  month;
    logic [YEAR_W-1:0]   year;
    logic [HOUR_W-1:0]   hour;
    logic [MINUTE_W-1:0] minute;
    logic                ovf;
  } cal_stamp_t;

  // ports of the block
  logic                clk               = 1'b0;
  logic                rst_n             = 1'b0;
  logic                start             = 1'b0;
  logic                busy;
  logic                in_func           = FUNC_LOAD;
  logic [DAY_W-1:0]    in_load_day       = '0;
  logic [MONTH_W-1:0]  in_load_month     = '0;
  logic [YEAR_W-1:0]   in_load_year      = '0;
  logic [HOUR_W-1:0]   in_load_hour      = '0;
  logic [MINUTE_W-1:0] in_load_minute    = '0;
  logic [19:0]         in_add_amount     = '0;
  logic                out_valid;
  logic [DAY_W-1:0]    out_cur_day;
  logic [MONTH_W-1:0]  out_cur_month;
  logic [YEAR_W-1:0]   out_cur_year;
  logic [HOUR_W-1:0]   out_cur_hour;
  logic [MINUTE_W-1:0] out_cur_minute;
  logic                out_year_overflow;

  // stimulus and expectation stores
  cal_cmd_t   pending_cmds[$];
  cal_stamp_t expected_stamps[$];
  cal_cmd_t   next_cmd;
  cal_cmd_t   held_cmd;
  cal_stamp_t oldest_stamp;

  // predicted calendar state, reset value 01-01-0001 00:00
  int unsigned now_day    = 1;
  int unsigned now_month  = 1;
  int unsigned now_year   = 1;
  int unsigned now_hour   = 0;
  int unsigned now_minute = 0;

  // burst and gap pacing of the sender
  int burst_left = 1;
  int gap_left   = 0;

  // run statistics
  int mismatch_count  = 0;
  int transfer_count  = 0;
  int load_count      = 0;
  int add_count       = 0;
  int result_count    = 0;
  int overflow_count  = 0;
  int leap_day_count  = 0;
  int months_walked   = 0;
  int cycle_count     = 0;

  calendar_minute_adder u_top (
    .clk               (clk),
    .rst_n             (rst_n),
    .start             (start),
    .busy              (busy),
    .in_func           (in_func),
    .in_load_day       (in_load_day),
    .in_load_month     (in_load_month),
    .in_load_year      (in_load_year),
    .in_load_hour      (in_load_hour),
    .in_load_minute    (in_load_minute),
    .in_add_amount     (in_add_amount),
    .out_valid         (out_valid),
    .out_cur_day       (out_cur_day),
    .out_cur_month     (out_cur_month),
    .out_cur_year      (out_cur_year),
    .out_cur_hour      (out_cur_hour),
    .out_cur_minute    (out_cur_minute),
    .out_year_overflow (out_year_overflow)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // calendar predictor
  // ---------------------------------------------------------------------------

  // length of month m in year y, gregorian leap rule
  function automatic int unsigned month_length(int unsigned m, int unsigned y);
    logic        leap;
    int unsigned len;
    leap = ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
    case (m)
      MON_FEB:                            len = leap ? 29 : 28;
      MON_APR, MON_JUN, MON_SEP, MON_NOV: len = 30;
      default:                            len = 31;
    endcase
    return len;
  endfunction

  function automatic int unsigned clamp_to(int unsigned v, int unsigned lo, int unsigned hi);
    if (v < lo) return lo;
    if (v > hi) return hi;
    return v;
  endfunction

  // apply one command to the predicted calendar and return the date it shows
  function automatic cal_stamp_t advance_calendar(cal_cmd_t c);
    int unsigned amt;
    int unsigned mins;
    int unsigned hrs;
    int unsigned days;
    int unsigned mon;
    int unsigned yr;
    logic        ovf;
    cal_stamp_t  r;
    ovf = 1'b0;
    if (c.func == FUNC_LOAD) begin
      // out of range fields are clamped, a day past the month end is kept
      now_day    = clamp_to(32'(c.day), 1, LAST_DAY);
      now_month  = clamp_to(32'(c.month), 1, YEAR_MONS);
      now_year   = clamp_to(32'(c.year), 1, LAST_YEAR);
      now_hour   = clamp_to(32'(c.hour), 0, DAY_HOURS - 1);
      now_minute = clamp_to(32'(c.minute), 0, HOUR_MINS - 1);
      load_count++;
    end else begin
      amt  = 32'(c.amount) & ((32'd1 << ADD_WIDTH) - 32'd1);
      mins = now_minute + amt;
      hrs  = now_hour + mins / HOUR_MINS;
      days = now_day + hrs / DAY_HOURS;
      mon  = now_month;
      yr   = now_year;
      now_minute = mins % HOUR_MINS;
      now_hour   = hrs % DAY_HOURS;
      // walk whole months until the day fits, stop when the year would pass
      while (!ovf && days > month_length(mon, yr)) begin
        days -= month_length(mon, yr);
        mon++;
        months_walked++;
        if (mon > YEAR_MONS) begin
          mon = 1;
          if (yr >= LAST_YEAR) ovf = 1'b1;
          else yr++;
        end
      end
      if (ovf) begin
        now_day    = LAST_DAY;
        now_month  = YEAR_MONS;
        now_year   = LAST_YEAR;
        now_hour   = DAY_HOURS - 1;
        now_minute = HOUR_MINS - 1;
        overflow_count++;
      end else begin
        now_day   = days;
        now_month = mon;
        now_year  = yr;
      end
      add_count++;
    end
    if (now_day == 29 && now_month == MON_FEB) leap_day_count++;
    r.day    = DAY_W'(now_day);
    r.month  = MONTH_W'(now_month);
    r.year   = YEAR_W'(now_year);
    r.hour   = HOUR_W'(now_hour);
    r.minute = MINUTE_W'(now_minute);
    r.ovf    = ovf;
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // reporting
  // ---------------------------------------------------------------------------

  task automatic report_mismatch(string what);
    $display("[%0t] error: %s", $realtime, what);
    mismatch_count++;
  endtask

  task automatic compare_field(string name, logic [31:0] got, logic [31:0] want);
    if (got !== want)
      report_mismatch($sformatf("result %0d %s: got %0d, expected %0d",
                                result_count, name, got, want));
  endtask

  // ---------------------------------------------------------------------------
  // command queue fillers
  // ---------------------------------------------------------------------------

  // unused amount is randomised so it cannot mask a decode slip
  task automatic push_load(input int unsigned d, m, y, h, mi);
    cal_cmd_t c;
    c.func   = FUNC_LOAD;
    c.day    = DAY_W'(d);
    c.month  = MONTH_W'(m);
    c.year   = YEAR_W'(y);
    c.hour   = HOUR_W'(h);
    c.minute = MINUTE_W'(mi);
    c.amount = 20'($urandom);
    pending_cmds.push_back(c);
  endtask

  // load fields are don't care on an add, drive them with noise
  task automatic push_add(input int unsigned amt);
    cal_cmd_t c;
    c.func   = FUNC_ADD;
    c.day    = DAY_W'($urandom);
    c.month  = MONTH_W'($urandom);
    c.year   = YEAR_W'($urandom);
    c.hour   = HOUR_W'($urandom);
    c.minute = MINUTE_W'($urandom);
    c.amount = 20'(amt);
    pending_cmds.push_back(c);
  endtask

  // ---------------------------------------------------------------------------
  // driver: one command per transfer, start held high until busy lets it in
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst_n) begin
      start <= 1'b0;
    end else if (!(start && busy)) begin
      if (start) begin
        // transfer at this edge: predict its result now
        expected_stamps.push_back(advance_calendar(held_cmd));
        transfer_count++;
      end
      if (gap_left > 0) begin
        gap_left--;
        start <= 1'b0;
      end else if (pending_cmds.size() > 0) begin
        next_cmd = pending_cmds.pop_front();
        held_cmd = next_cmd;
        in_func        <= next_cmd.func;
        in_load_day    <= next_cmd.day;
        in_load_month  <= next_cmd.month;
        in_load_year   <= next_cmd.year;
        in_load_hour   <= next_cmd.hour;
        in_load_minute <= next_cmd.minute;
        in_add_amount  <= next_cmd.amount;
        start          <= 1'b1;
        if (burst_left > 1) begin
          burst_left--;
        end else begin
          // long bursts give stretches with no idling, gaps land anywhere
          burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(20, 60)
                                                   : $urandom_range(1, 8);
          gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 80);
        end
      end else begin
        start <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // monitor: every strobe is one result transfer, checked against the oldest
  // expected date
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      if (expected_stamps.size() == 0) begin
        report_mismatch("result strobe with no command outstanding");
      end else begin
        oldest_stamp = expected_stamps.pop_front();
        compare_field("day",    32'(out_cur_day),    32'(oldest_stamp.day));
        compare_field("month",  32'(out_cur_month),  32'(oldest_stamp.month));
        compare_field("year",   32'(out_cur_year),   32'(oldest_stamp.year));
        compare_field("hour",   32'(out_cur_hour),   32'(oldest_stamp.hour));
        compare_field("minute", 32'(out_cur_minute), 32'(oldest_stamp.minute));
        compare_field("year_overflow", 32'(out_year_overflow), 32'(oldest_stamp.ovf));
      end
      result_count++;
    end
  end

  // watchdog on the cycle count
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("[%0t] error: timeout after %0d cycles", $realtime, cycle_count);
      $display("end of test: mismatches");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // stimulus and end of run
  // ---------------------------------------------------------------------------
  initial begin
    int          random_items;
    int unsigned adds;
    int unsigned amt;
    int unsigned yr;
    int unsigned pick;

    // directed part: from reset state, clamps at both ends
    push_add(0);
    push_load(0, 0, 0, 0, 0);
    push_add(59);
    push_add(1);
    push_add(1439);
    push_load(31, 15, 16383, 31, 63);
    push_add(0);
    // year saturation, then again from the saturated date
    push_add(1);
    push_add(1048575);
    // leap day on a 400 year, none on a plain century, one on a 4 year
    push_load(28, 2, 2000, 23, 59);
    push_add(1);
    push_add(1440);
    push_load(28, 2, 1900, 23, 59);
    push_add(1);
    push_load(28, 2, 2024, 23, 59);
    push_add(1);
    // day past the month end kept by a load, carried by an add of zero
    push_load(31, 2, 2023, 12, 0);
    push_add(0);
    push_load(31, 4, 2100, 0, 0);
    push_add(0);
    // new year and the largest amount near the top year
    push_load(31, 12, 1999, 23, 59);
    push_add(1);
    push_load(1, 1, 9998, 0, 0);
    push_add(1048575);
    push_add(1048575);

    // random part: a load followed by a run of adds, with raw loads as noise
    random_items = 0;
    while (random_items < RANDOM_ITEMS) begin
      pick = $urandom_range(0, 99);
      case ($urandom_range(0, 9))
        0, 1, 2, 3: yr = $urandom_range(1, 9999);
        4, 5, 6:    yr = $urandom_range(1, 99) * 100 + $urandom_range(0, 4) - 2;
        7, 8:       yr = $urandom_range(9996, 9999);
        default:    yr = $urandom_range(1, 3);
      endcase
      if (pick < 55)
        push_load($urandom_range(1, 31), $urandom_range(1, 12), yr,
                  $urandom_range(0, 23), $urandom_range(0, 59));
      else if (pick < 75)
        push_load($urandom_range(28, 31), $urandom_range(1, 12), yr,
                  23, $urandom_range(50, 59));
      else
        push_load($urandom_range(0, 31), $urandom_range(0, 15),
                  $urandom_range(0, 16383), $urandom_range(0, 31),
                  $urandom_range(0, 63));
      random_items++;

      adds = $urandom_range(0, 6);
      repeat (adds) begin
        pick = $urandom_range(0, 99);
        if (pick < 15) begin
          amt = $urandom_range(0, 59);
        end else if (pick < 30) begin
          amt = $urandom_range(0, 1440);
        end else if (pick < 45) begin
          case ($urandom_range(0, 7))
            0:       amt = 1;
            1:       amt = 59;
            2:       amt = 60;
            3:       amt = 1439;
            4:       amt = 1440;
            5:       amt = 1441;
            6:       amt = 525600;
            default: amt = 527040;
          endcase
        end else if (pick < 70) begin
          amt = $urandom_range(0, 50000);
        end else if (pick < 90) begin
          amt = $urandom & 32'hFFFFF;
        end else begin
          amt = 1048575 - $urandom_range(0, 1000);
        end
        push_add(amt);
        random_items++;
      end
    end

    // reset, then let the driver run the queue dry
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    while (pending_cmds.size() != 0 || start) @(posedge clk);
    while (expected_stamps.size() != 0) @(posedge clk);
    // catch any stray strobe after the last result
    repeat (DRAIN_CYCLES) @(posedge clk);

    while (expected_stamps.size() != 0) begin
      oldest_stamp = expected_stamps.pop_front();
      report_mismatch("expected result never arrived");
    end

    $display("summary: %0d transfers (%0d loads, %0d adds), %0d results checked",
             transfer_count, load_count, add_count, result_count);
    $display("summary: %0d year saturations, %0d dates on 29 february, %0d months walked",
             overflow_count, leap_day_count, months_walked);
    if (mismatch_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
